>>> rtl/bpd_pkg.sv
// Package with the request and response payload types and the decode constants.
`default_nettype none

package bpd_pkg;

   localparam int TILE_SLOT_W = 10;
   localparam int BATT_DEPTH = 256;
   localparam int BATT_AW = $clog2(BATT_DEPTH);

   typedef enum logic [2:0] {
      OP_PORT_ONE   = 3'd0,
      OP_PORT_TWO   = 3'd1,
      OP_PROG_LINE  = 3'd2,
      OP_IO_WRITE   = 3'd3,
      OP_IO_READ    = 3'd4,
      OP_TILE_FETCH = 3'd5
   } opcode_type;

   typedef enum logic [2:0] {
      EXT_NONE       = 3'd0,
      EXT_CRTC_ADDR  = 3'd1,
      EXT_CRTC_REG   = 3'd2,
      EXT_SOUND_ADDR = 3'd3,
      EXT_SOUND_DATA = 3'd4,
      EXT_SOUND_READ = 3'd5
   } ext_target_type;

   // Port two selects.
   localparam logic [7:0] P2_TILE_CODE  = 8'h3f;
   localparam logic [7:0] P2_TILE_COLOR = 8'h7f;
   localparam logic [7:0] P2_BATTERY    = 8'hfb;
   localparam logic [7:0] P2_BATT_READ  = 8'h7b;
   localparam logic [7:0] P2_CRTC_ADDR  = 8'hc7;
   localparam logic [7:0] P2_CRTC_REG   = 8'hd7;
   localparam logic [7:0] P2_EXTENDED   = 8'hff;

   // Port one selects under the extended port two value.
   localparam logic [7:0] P1_COUNTER    = 8'hf7;
   localparam logic [7:0] P1_LAMP       = 8'hef;
   localparam logic [7:0] P1_SOUND_ADDR = 8'hfc;
   localparam logic [7:0] P1_SOUND_DATA = 8'hfe;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [7:0]  offset;
      logic [7:0]  data;
      logic [9:0]  tile_slot;
      logic [6:0]  key_inputs;
      logic [15:0] button_inputs;
      logic [7:0]  sound_read_data;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [2:0]  ext_target;
      logic [7:0]  ext_data;
      logic [3:0]  coin_counters;
      logic        hopper_motor;
      logic [7:0]  lamp_bits;
      logic        program_bank;
      logic [15:0] tile_code;
      logic [3:0]  tile_color;
   } rsp_payload_type;

endpackage

`default_nettype wire

>>> rtl/bpd_if.sv
// Valid/ready channel interfaces for the request and response sides.
`default_nettype none

interface bpd_req_if;
   import bpd_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface bpd_rsp_if;
   import bpd_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/board_io_port_decoder.sv
// Board I/O port decoder: port latches, external I/O decode, memories and tile fetch.
// A request passes the input register, then the output register; a stalled response holds it in the first.
// One request per cycle unless rsp stalls or the clearing pass runs; memories use one read and one write port.
// A tile color write is a read-modify-write, with the write forwarded to the next read.
// Reset clears all latches, then a clearing pass over every tile address zeroes the memories.
// No request is accepted during that pass.
`default_nettype none

module board_io_port_decoder
   import bpd_pkg::*;
#(
   parameter int TILE_DEPTH = 1024
) (
   input wire logic  clock,
   input wire logic  reset,
   bpd_req_if.sink   req,
   bpd_rsp_if.source rsp
);

   localparam int TileAw = $clog2(TILE_DEPTH);
   localparam int IdxW = (TileAw > TILE_SLOT_W) ? TileAw : TILE_SLOT_W;

   logic [15:0]        tile_code_mem  [TILE_DEPTH];
   logic [3:0]         tile_color_mem [TILE_DEPTH];
   logic [7:0]         batt_mem       [BATT_DEPTH];

   logic               clear_active_ff;
   logic [TileAw-1:0]  clear_addr_ff;

   logic               s1_valid_ff;
   req_payload_type    s1_req_ff;
   logic [15:0]        code_rd_ff;
   logic [3:0]         color_rd_ff;
   logic [7:0]         batt_rd_ff;

   logic               out_valid_ff;
   rsp_payload_type    out_ff;
   rsp_payload_type    out_in;

   logic [7:0]         port_one_ff, port_one_in;
   logic [7:0]         port_two_ff, port_two_in;
   logic               bank_ff, bank_in;
   logic [3:0]         counter_ff, counter_in;
   logic               hopper_ff, hopper_in;
   logic [6:0]         lamp_ff, lamp_in;

   logic               s1_adv;
   logic               req_acc;
   logic [9:0]         s1_cell;
   logic               s1_cell_ok;
   logic               s1_fetch_ok;
   logic               code_we, color_we, batt_we;
   logic [15:0]        code_wdata;
   logic [3:0]         color_wdata;
   logic [7:0]         batt_wdata;
   logic [TileAw-1:0]  tile_waddr;
   logic [BATT_AW-1:0] batt_waddr;
   logic               tile_code_wen, tile_color_wen, batt_wen;
   logic [9:0]         rd_cell;
   logic [TileAw-1:0]  tile_raddr;

   function automatic logic [7:0] encode_keys(input logic [6:0] k);
      logic [7:0] r;
      case (k)
         7'h00:   r = 8'hc0;
         7'h01:   r = 8'hc4;
         7'h02:   r = 8'hc6;
         7'h04:   r = 8'hc8;
         7'h08:   r = 8'hd0;
         7'h10:   r = 8'he0;
         7'h20:   r = 8'h80;
         7'h40:   r = 8'h40;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] encode_buttons(input logic [15:0] b);
      logic [7:0] r;
      logic [3:0] k;
      k = 4'd0;
      for (int i = 0; i < 16; i++) begin
         if (b[i]) begin
            k = 4'(i);
         end
      end
      if (b == 16'h0000) begin
         r = 8'h80;
      end else if ((b & (b - 16'd1)) != 16'h0000) begin
         r = 8'h00;
      end else if (k < 4'd8) begin
         r = 8'h81 + {5'd0, k[2:0]};
      end else if (k < 4'd14) begin
         r = 8'h90 + {2'd0, k[2:0], 3'd0};
      end else if (k == 4'd14) begin
         r = 8'hc0;
      end else begin
         r = 8'h00;
      end
      return r;
   endfunction

   // Handshake.
   assign s1_adv  = s1_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !clear_active_ff && (!s1_valid_ff || s1_adv);
   assign req_acc = req.valid && req.ready;

   // Decode of the request held in the input register.
   assign s1_cell     = {port_one_ff[7:6], s1_req_ff.offset};
   assign s1_cell_ok  = (IdxW + 1)'(s1_cell) < (IdxW + 1)'(TILE_DEPTH);
   assign s1_fetch_ok = (IdxW + 1)'(s1_req_ff.tile_slot) < (IdxW + 1)'(TILE_DEPTH);

   always_comb begin
      port_one_in = port_one_ff;
      port_two_in = port_two_ff;
      bank_in     = bank_ff;
      counter_in  = counter_ff;
      hopper_in   = hopper_ff;
      lamp_in     = lamp_ff;
      code_we     = 1'b0;
      color_we    = 1'b0;
      batt_we     = 1'b0;
      code_wdata  = {8'h00, s1_req_ff.data};
      color_wdata = s1_req_ff.data[3:0];
      batt_wdata  = s1_req_ff.data;
      out_in      = '0;
      if (s1_adv) begin
         case (s1_req_ff.opcode)
            OP_PORT_ONE: begin
               port_one_in = s1_req_ff.data;
            end
            OP_PORT_TWO: begin
               port_two_in = s1_req_ff.data;
            end
            OP_PROG_LINE: begin
               bank_in = bank_ff ^ s1_req_ff.data[0];
            end
            OP_IO_WRITE: begin
               case (port_two_ff)
                  P2_TILE_CODE: begin
                     code_we = s1_cell_ok;
                  end
                  P2_TILE_COLOR: begin
                     code_we    = s1_cell_ok;
                     color_we   = s1_cell_ok;
                     code_wdata = code_rd_ff + {4'h0, s1_req_ff.data[7:4], 8'h00};
                  end
                  P2_BATTERY: begin
                     batt_we = 1'b1;
                  end
                  P2_CRTC_ADDR: begin
                     out_in.ext_target = EXT_CRTC_ADDR;
                  end
                  P2_CRTC_REG: begin
                     out_in.ext_target = EXT_CRTC_REG;
                  end
                  P2_EXTENDED: begin
                     case (port_one_ff)
                        P1_COUNTER: begin
                           counter_in = s1_req_ff.data[3:0];
                           hopper_in  = s1_req_ff.data[4] & s1_req_ff.data[5];
                        end
                        P1_LAMP: begin
                           lamp_in = s1_req_ff.data[6:0];
                        end
                        P1_SOUND_ADDR: begin
                           out_in.ext_target = EXT_SOUND_ADDR;
                        end
                        P1_SOUND_DATA: begin
                           out_in.ext_target = EXT_SOUND_DATA;
                        end
                        default: begin
                        end
                     endcase
                  end
                  default: begin
                  end
               endcase
               if (out_in.ext_target != EXT_NONE) begin
                  out_in.ext_data = s1_req_ff.data;
               end
            end
            OP_IO_READ: begin
               if (port_two_ff inside {P2_BATT_READ, P2_BATTERY}) begin
                  out_in.read_data = batt_rd_ff;
               end else if (port_two_ff == P2_EXTENDED) begin
                  case (port_one_ff)
                     P1_SOUND_DATA: begin
                        out_in.read_data  = s1_req_ff.sound_read_data;
                        out_in.ext_target = EXT_SOUND_READ;
                     end
                     P1_LAMP: begin
                        out_in.read_data = encode_keys(s1_req_ff.key_inputs);
                     end
                     P1_COUNTER: begin
                        out_in.read_data = encode_buttons(s1_req_ff.button_inputs);
                     end
                     default: begin
                     end
                  endcase
               end
            end
            OP_TILE_FETCH: begin
               if (s1_fetch_ok) begin
                  out_in.tile_code  = code_rd_ff;
                  out_in.tile_color = color_rd_ff;
               end
            end
            default: begin
            end
         endcase
      end
      out_in.coin_counters = counter_in;
      out_in.hopper_motor  = hopper_in;
      out_in.lamp_bits     = {hopper_in, lamp_in};
      out_in.program_bank  = bank_in;
   end

   // Memory ports: the clearing pass owns the write port until it finishes.
   assign tile_waddr     = clear_active_ff ? clear_addr_ff : TileAw'(s1_cell);
   assign batt_waddr     = clear_active_ff ? clear_addr_ff[BATT_AW-1:0] : s1_req_ff.offset;
   assign tile_code_wen  = clear_active_ff || code_we;
   assign tile_color_wen = clear_active_ff || color_we;
   assign batt_wen       = clear_active_ff || batt_we;

   assign rd_cell    = {port_one_in[7:6], req.payload.offset};
   assign tile_raddr = (req.payload.opcode == OP_TILE_FETCH) ?
                       TileAw'(req.payload.tile_slot) : TileAw'(rd_cell);

   always_ff @(posedge clock) begin
      if (tile_code_wen) begin
         tile_code_mem[tile_waddr] <= clear_active_ff ? 16'h0000 : code_wdata;
      end
      if (req_acc) begin
         code_rd_ff <= (code_we && tile_waddr == tile_raddr) ?
                       code_wdata : tile_code_mem[tile_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (tile_color_wen) begin
         tile_color_mem[tile_waddr] <= clear_active_ff ? 4'h0 : color_wdata;
      end
      if (req_acc) begin
         color_rd_ff <= (color_we && tile_waddr == tile_raddr) ?
                        color_wdata : tile_color_mem[tile_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (batt_wen) begin
         batt_mem[batt_waddr] <= clear_active_ff ? 8'h00 : batt_wdata;
      end
      if (req_acc) begin
         batt_rd_ff <= (batt_we && batt_waddr == req.payload.offset) ?
                       batt_wdata : batt_mem[req.payload.offset];
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_active_ff <= 1'b1;
         clear_addr_ff   <= '0;
         s1_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         port_one_ff     <= '0;
         port_two_ff     <= '0;
         bank_ff         <= 1'b0;
         counter_ff      <= '0;
         hopper_ff       <= 1'b0;
         lamp_ff         <= '0;
      end else begin
         if (clear_active_ff) begin
            clear_addr_ff <= clear_addr_ff + TileAw'(1);
            if (clear_addr_ff == TileAw'(TILE_DEPTH - 1)) begin
               clear_active_ff <= 1'b0;
            end
         end
         if (req_acc) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
         port_one_ff <= port_one_in;
         port_two_ff <= port_two_in;
         bank_ff     <= bank_in;
         counter_ff  <= counter_in;
         hopper_ff   <= hopper_in;
         lamp_ff     <= lamp_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_req_ff <= req.payload;
      end
      if (s1_adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = out_ff;

   a_clear_blocks_requests: assert property (@(posedge clock) disable iff (reset)
      clear_active_ff |-> !req.ready)
      else $error("request accepted during the memory clearing pass");

   a_advance_gives_response: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> out_valid_ff)
      else $error("request left the input register without a response");

   a_ext_data_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_ff.ext_target == EXT_NONE || out_ff.ext_target == EXT_SOUND_READ)
      |-> out_ff.ext_data == 8'h00)
      else $error("external data driven without a write strobe");

   a_write_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      (code_we || color_we || batt_we) |-> s1_valid_ff && !clear_active_ff)
      else $error("memory write without a request in the input register");

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the board I/O port decoder with directed and random request traffic.
`timescale 1ns / 1ps

module tb;
   import bpd_pkg::*;

   localparam int TILE_CELLS = 1024;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 20;
   localparam int RECENT_MAX = 32;
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bpd_req_if req_ch ();
   bpd_rsp_if rsp_ch ();

   board_io_port_decoder uut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch)
   );

   always #1 clock = ~clock;

   // Mirror of the board state.
   logic [7:0]  port_one;
   logic [7:0]  port_two;
   logic        bank;
   logic [3:0]  coin_latch;
   logic        hopper;
   logic [6:0]  lamp_latch;
   logic [15:0] code_cells [0:TILE_CELLS-1];
   logic [3:0]  color_cells [0:TILE_CELLS-1];
   logic [7:0]  battery_cells [0:255];

   rsp_payload_type board_outputs_due [$];
   int recent_cells [$];
   int recent_battery [$];

   int sender_idle_pct;
   int receiver_idle_pct;
   int items_sent = 0;
   int responses_seen = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int op_count [0:7];

   function automatic logic [7:0] key_code(input logic [6:0] keys);
      case (keys)
         7'h00: return 8'hc0;
         7'h01: return 8'hc4;
         7'h02: return 8'hc6;
         7'h04: return 8'hc8;
         7'h08: return 8'hd0;
         7'h10: return 8'he0;
         7'h20: return 8'h80;
         7'h40: return 8'h40;
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] button_code(input logic [15:0] buttons);
      int k = 0;
      if (buttons == 16'h0000) return 8'h80;
      if ((buttons & (buttons - 16'h0001)) != 16'h0000) return 8'h00;
      while (!buttons[k]) k++;
      if (k < 8) return 8'(8'h81 + k);
      if (k < 14) return 8'(8'h90 + 8 * (k - 8));
      if (k == 14) return 8'hc0;
      return 8'h00;
   endfunction

   function automatic rsp_payload_type predict_board(input req_payload_type rq);
      rsp_payload_type r;
      int cell_addr;
      r = '0;
      cell_addr = int'({port_one[7:6], rq.offset});
      case (rq.opcode)
         OP_PORT_ONE: port_one = rq.data;
         OP_PORT_TWO: port_two = rq.data;
         OP_PROG_LINE: begin
            if (rq.data[0]) bank = ~bank;
         end
         OP_IO_WRITE: begin
            if (port_two == P2_CRTC_ADDR) r.ext_target = EXT_CRTC_ADDR;
            else if (port_two == P2_CRTC_REG) r.ext_target = EXT_CRTC_REG;
            else if (port_two == P2_EXTENDED && port_one == P1_SOUND_ADDR)
               r.ext_target = EXT_SOUND_ADDR;
            else if (port_two == P2_EXTENDED && port_one == P1_SOUND_DATA)
               r.ext_target = EXT_SOUND_DATA;
            if (r.ext_target != EXT_NONE) r.ext_data = rq.data;
            case (port_two)
               P2_TILE_CODE: begin
                  code_cells[cell_addr] = {8'h00, rq.data};
                  recent_cells.push_back(cell_addr);
               end
               P2_TILE_COLOR: begin
                  color_cells[cell_addr] = rq.data[3:0];
                  code_cells[cell_addr] = code_cells[cell_addr] + {4'h0, rq.data[7:4], 8'h00};
                  recent_cells.push_back(cell_addr);
               end
               P2_BATTERY: begin
                  battery_cells[rq.offset] = rq.data;
                  recent_battery.push_back(int'(rq.offset));
               end
               P2_EXTENDED: begin
                  if (port_one == P1_COUNTER) begin
                     coin_latch = rq.data[3:0];
                     hopper = rq.data[4] & rq.data[5];
                  end else if (port_one == P1_LAMP) begin
                     lamp_latch = rq.data[6:0];
                  end
               end
               default: ;
            endcase
            if (recent_cells.size() > RECENT_MAX) void'(recent_cells.pop_front());
            if (recent_battery.size() > RECENT_MAX) void'(recent_battery.pop_front());
         end
         OP_IO_READ: begin
            if (port_two == P2_BATT_READ || port_two == P2_BATTERY) begin
               r.read_data = battery_cells[rq.offset];
            end else if (port_two == P2_EXTENDED) begin
               if (port_one == P1_SOUND_DATA) begin
                  r.read_data = rq.sound_read_data;
                  r.ext_target = EXT_SOUND_READ;
               end else if (port_one == P1_LAMP) begin
                  r.read_data = key_code(rq.key_inputs);
               end else if (port_one == P1_COUNTER) begin
                  r.read_data = button_code(rq.button_inputs);
               end
            end
         end
         OP_TILE_FETCH: begin
            r.tile_code = code_cells[rq.tile_slot];
            r.tile_color = color_cells[rq.tile_slot];
         end
         default: ;
      endcase
      r.coin_counters = coin_latch;
      r.hopper_motor = hopper;
      r.lamp_bits = {hopper, lamp_latch};
      r.program_bank = bank;
      return r;
   endfunction

   function automatic req_payload_type random_request();
      req_payload_type item;
      item.opcode = OP_IO_READ;
      item.offset = 8'($urandom);
      item.data = 8'($urandom);
      item.tile_slot = 10'($urandom);
      item.key_inputs = $urandom_range(0, 1) ? 7'($urandom) : 7'(1 << $urandom_range(0, 7));
      item.button_inputs = $urandom_range(0, 1) ? 16'($urandom)
                                                 : 16'(1 << $urandom_range(0, 16));
      item.sound_read_data = 8'($urandom);
      return item;
   endfunction

   function automatic req_payload_type make_op(input logic [2:0] op, input logic [7:0] offset,
                                               input logic [7:0] data);
      req_payload_type item;
      item = random_request();
      item.opcode = op;
      item.offset = offset;
      item.data = data;
      return item;
   endfunction

   function automatic logic [7:0] pick_port_two();
      case ($urandom_range(0, 7))
         0: return P2_TILE_CODE;
         1: return P2_TILE_COLOR;
         2: return P2_BATTERY;
         3: return P2_BATT_READ;
         4: return P2_CRTC_ADDR;
         5: return P2_CRTC_REG;
         6: return P2_EXTENDED;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_port_one();
      case ($urandom_range(0, 5))
         0: return P1_COUNTER;
         1: return P1_LAMP;
         2: return P1_SOUND_ADDR;
         3: return P1_SOUND_DATA;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic req_payload_type random_operation();
      req_payload_type item;
      int roll;
      item = random_request();
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
         item.opcode = OP_IO_WRITE;
      end else if (roll < 65) begin
         item.opcode = OP_IO_READ;
         if (recent_battery.size() != 0 && $urandom_range(0, 1))
            item.offset = 8'(recent_battery[$urandom_range(0, recent_battery.size() - 1)]);
      end else if (roll < 85) begin
         item.opcode = OP_TILE_FETCH;
         if (recent_cells.size() != 0 && $urandom_range(0, 2) != 0)
            item.tile_slot = 10'(recent_cells[$urandom_range(0, recent_cells.size() - 1)]);
      end else if (roll < 93) begin
         item.opcode = OP_PROG_LINE;
      end else if (roll < 97) begin
         item.opcode = $urandom_range(0, 1) ? OP_PORT_ONE : OP_PORT_TWO;
      end else begin
         item.opcode = $urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI;
      end
      return item;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < 40) $display("[%0t] mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string field, input logic [15:0] seen,
                              input logic [15:0] want);
      if (seen !== want)
         report_mismatch($sformatf("response %0d %s is %h, expected %h",
                                   responses_seen, field, seen, want));
   endtask

   // Called at a falling edge; returns at the falling edge after the request is taken.
   task automatic send_request(input req_payload_type item);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= item;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board_outputs_due.push_back(predict_board(item));
      op_count[item.opcode]++;
      items_sent++;
      @(negedge clock);
   endtask

   task automatic test_bank_toggle();
      send_request(make_op(OP_PROG_LINE, 8'h00, 8'h01));
      send_request(make_op(OP_PROG_LINE, 8'hff, 8'hfe));
   endtask

   task automatic test_tile_cells();
      req_payload_type item;
      send_request(make_op(OP_PORT_ONE, 8'h00, 8'hc0));
      send_request(make_op(OP_PORT_TWO, 8'h00, P2_TILE_CODE));
      send_request(make_op(OP_IO_WRITE, 8'hff, 8'hff));
      send_request(make_op(OP_PORT_TWO, 8'h00, P2_TILE_COLOR));
      send_request(make_op(OP_IO_WRITE, 8'hff, 8'hf3));
      item = make_op(OP_TILE_FETCH, 8'h00, 8'h00);
      item.tile_slot = 10'h3ff;
      send_request(item);
   endtask

   task automatic test_battery_ram();
      send_request(make_op(OP_PORT_TWO, 8'h00, P2_BATTERY));
      send_request(make_op(OP_IO_WRITE, 8'h00, 8'ha5));
      send_request(make_op(OP_IO_READ, 8'h00, 8'h00));
      send_request(make_op(OP_PORT_TWO, 8'h00, P2_BATT_READ));
      send_request(make_op(OP_IO_READ, 8'h00, 8'hff));
   endtask

   task automatic test_chip_strobes();
      req_payload_type item;
      send_request(make_op(OP_PORT_TWO, 8'h00, P2_CRTC_ADDR));
      send_request(make_op(OP_IO_WRITE, 8'h12, 8'h5a));
      send_request(make_op(OP_PORT_TWO, 8'h00, P2_EXTENDED));
      send_request(make_op(OP_PORT_ONE, 8'h00, P1_SOUND_DATA));
      item = make_op(OP_IO_READ, 8'h00, 8'h00);
      item.sound_read_data = 8'hff;
      send_request(item);
      send_request(make_op(OP_IO_WRITE, 8'h00, 8'h81));
   endtask

   task automatic test_coin_and_lamps();
      send_request(make_op(OP_PORT_ONE, 8'h00, P1_COUNTER));
      send_request(make_op(OP_IO_WRITE, 8'h00, 8'h3f));
      send_request(make_op(OP_PORT_ONE, 8'h00, P1_LAMP));
      send_request(make_op(OP_IO_WRITE, 8'h00, 8'hff));
   endtask

   task automatic test_switch_encoders();
      req_payload_type item;
      item = make_op(OP_IO_READ, 8'h00, 8'h00);
      item.key_inputs = 7'h03;
      send_request(item);
      send_request(make_op(OP_PORT_ONE, 8'h00, P1_COUNTER));
      item = make_op(OP_IO_READ, 8'h00, 8'h00);
      item.button_inputs = 16'h8000;
      send_request(item);
   endtask

   task automatic test_spare_opcodes();
      send_request(make_op(OP_SPARE_HI, 8'h00, 8'h00));
      send_request(make_op(OP_SPARE_LO, 8'hff, 8'hff));
   endtask

   // Mostly latch setups followed by bursts of accesses, with an occasional bare burst.
   task automatic test_random_traffic(input int quota);
      int goal;
      req_payload_type item;
      goal = items_sent + quota;
      while (items_sent < goal) begin
         if ($urandom_range(0, 9) < 8) begin
            item = make_op(OP_PORT_TWO, 8'h00, pick_port_two());
            send_request(item);
            item = make_op(OP_PORT_ONE, 8'h00, pick_port_one());
            send_request(item);
         end
         repeat ($urandom_range(1, 8)) send_request(random_operation());
      end
   endtask

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   always @(posedge clock) begin : response_checker
      rsp_payload_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (board_outputs_due.size() == 0) begin
            report_mismatch($sformatf("response %0d arrived with nothing outstanding",
                                      responses_seen));
         end else begin
            want = board_outputs_due.pop_front();
            check_field("read_data", 16'(rsp_ch.payload.read_data), 16'(want.read_data));
            check_field("ext_target", 16'(rsp_ch.payload.ext_target), 16'(want.ext_target));
            check_field("ext_data", 16'(rsp_ch.payload.ext_data), 16'(want.ext_data));
            check_field("coin_counters", 16'(rsp_ch.payload.coin_counters),
                        16'(want.coin_counters));
            check_field("hopper_motor", 16'(rsp_ch.payload.hopper_motor),
                        16'(want.hopper_motor));
            check_field("lamp_bits", 16'(rsp_ch.payload.lamp_bits), 16'(want.lamp_bits));
            check_field("program_bank", 16'(rsp_ch.payload.program_bank),
                        16'(want.program_bank));
            check_field("tile_code", rsp_ch.payload.tile_code, want.tile_code);
            check_field("tile_color", 16'(rsp_ch.payload.tile_color), 16'(want.tile_color));
         end
         responses_seen++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding.",
                  cycle_count, board_outputs_due.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      foreach (code_cells[i]) begin
         code_cells[i] = '0;
         color_cells[i] = '0;
      end
      foreach (battery_cells[i]) battery_cells[i] = '0;
      foreach (op_count[i]) op_count[i] = 0;
      port_one = '0;
      port_two = '0;
      bank = 1'b0;
      coin_latch = '0;
      hopper = 1'b0;
      lamp_latch = '0;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      sender_idle_pct = 27;
      receiver_idle_pct = 72;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_bank_toggle();
      test_tile_cells();
      test_battery_ram();
      test_chip_strobes();
      test_coin_and_lamps();
      test_switch_encoders();
      test_spare_opcodes();

      test_random_traffic(530);
      sender_idle_pct = 72;
      receiver_idle_pct = 27;
      test_random_traffic(530);
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      test_random_traffic(530);
      req_ch.valid <= 1'b0;

      while (board_outputs_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests: %0d io writes, %0d io reads, %0d tile fetches, %0d other.",
               items_sent, op_count[OP_IO_WRITE], op_count[OP_IO_READ],
               op_count[OP_TILE_FETCH],
               items_sent - op_count[OP_IO_WRITE] - op_count[OP_IO_READ]
                          - op_count[OP_TILE_FETCH]);
      $display("Checked %0d responses under three idle patterns; %0d mismatches.",
               responses_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
